@@ hw/rtl/pse_pkg.sv @@
// Shared constants, types and codes for the postfix stack evaluator.
`default_nettype none

package pse_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int NUM_W       = 31;
  localparam int KIND_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int DEPTH_W     = 7;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_W);
  localparam int IN_DATA_W   = ((NUM_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = DATA_W + STATUS_W + DEPTH_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_NUMBER = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_SUB    = 3'd2,
    KIND_MUL    = 3'd3,
    KIND_DIV    = 3'd4,
    KIND_FINISH = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2,
    STATUS_DIVZERO   = 2'd3
  } status_t;

  // Per-cell move: keep, take from the neighbor above, take from the one below.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_POP  = 2'd2
  } cell_op_t;

  // Whole-stack move requested by the control.
  typedef enum logic [1:0] {
    STK_HOLD    = 2'd0,
    STK_PUSH    = 2'd1,
    STK_REPLACE = 2'd2
  } stk_op_t;

  typedef struct packed {
    stk_op_t           op;
    logic [DATA_W-1:0] value;
  } stk_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DIV  = 2'd2
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/pse_cell.sv @@
// One stack cell: a single entry that shifts toward either neighbor.
`default_nettype none

module pse_cell (
  input  wire                              clk,
  input  pse_pkg::cell_op_t                op,
  input  wire  [pse_pkg::DATA_W-1:0]       up_val,
  input  wire  [pse_pkg::DATA_W-1:0]       down_val,
  output logic [pse_pkg::DATA_W-1:0]       val
);

  always_ff @(posedge clk) begin
    unique case (op)
      pse_pkg::CELL_PUSH: val <= up_val;
      pse_pkg::CELL_POP:  val <= down_val;
      default:            val <= val;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/pse_stack.sv @@
// Row of stack cells; cell 0 is the top of the stack.
`default_nettype none

module pse_stack (
  input  wire                              clk,
  input  pse_pkg::stk_cmd_t                cmd,
  output logic [pse_pkg::DATA_W-1:0]       top0,
  output logic [pse_pkg::DATA_W-1:0]       top1
);

  logic [pse_pkg::DATA_W-1:0] vals [pse_pkg::STACK_DEPTH];
  pse_pkg::cell_op_t          ops  [pse_pkg::STACK_DEPTH];

  genvar i;
  generate
    for (i = 0; i < pse_pkg::STACK_DEPTH; i++) begin : g_cell
      logic [pse_pkg::DATA_W-1:0] up_val;
      logic [pse_pkg::DATA_W-1:0] down_val;

      // Cell 0 loads the new value; operators load the result there and pop the rest.
      always_comb begin
        unique case (cmd.op)
          pse_pkg::STK_PUSH:    ops[i] = pse_pkg::CELL_PUSH;
          pse_pkg::STK_REPLACE: ops[i] = (i == 0) ? pse_pkg::CELL_PUSH : pse_pkg::CELL_POP;
          default:              ops[i] = pse_pkg::CELL_HOLD;
        endcase
      end

      if (i == 0) begin : g_first
        assign up_val = cmd.value;
      end else begin : g_mid
        assign up_val = vals[i-1];
      end

      if (i == pse_pkg::STACK_DEPTH - 1) begin : g_last
        assign down_val = '0;
      end else begin : g_inner
        assign down_val = vals[i+1];
      end

      pse_cell u_cell (
        .clk      (clk),
        .op       (ops[i]),
        .up_val   (up_val),
        .down_val (down_val),
        .val      (vals[i])
      );
    end
  endgenerate

  assign top0 = vals[0];
  assign top1 = vals[1];

endmodule

`default_nettype wire

@@ hw/rtl/pse_div.sv @@
// Signed 32-bit divider, restoring, one quotient bit per cycle, truncates toward zero.
`default_nettype none

module pse_div (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  input  wire  [pse_pkg::DATA_W-1:0]       dividend,
  input  wire  [pse_pkg::DATA_W-1:0]       divisor,
  output logic                             done,
  output logic [pse_pkg::DATA_W-1:0]       quotient
);

  localparam int W = pse_pkg::DATA_W;

  logic                         busy;
  logic                         neg;
  logic [W-1:0]                 rem;
  logic [W-1:0]                 quo;
  logic [W-1:0]                 den;
  logic [pse_pkg::DIV_CNT_W-1:0] cnt;
  logic [W:0]                   rem_sh;
  logic [W:0]                   diff;

  assign rem_sh = {rem, quo[W-1]};
  assign diff   = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == pse_pkg::DIV_CNT_W'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[W-1] ^ divisor[W-1];
      rem <= '0;
      quo <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
      den <= divisor[W-1] ? (~divisor + 1'b1) : divisor;
    end else if (busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? (~quo + 1'b1) : quo;

endmodule

`default_nettype wire

@@ hw/rtl/postfix_stack_evaluator.sv @@
// Top level of the postfix stack evaluator: token control, stack row, divider, result register.
//
//  Channel | Dir | Signals                      | Word contents (low bit up)
//  --------+-----+------------------------------+-------------------------------------------
//  s_axis  | in  | tvalid tready tdata tuser    | tdata: number[30:0]; tuser: kind[2:0]
//  m_axis  | out | tvalid tready tdata tuser    | tdata: top_value[31:0] status[33:32]
//          |     |                              |        depth[40:34]; tuser: is_answer
//
// A token word is accepted in ST_IDLE, then evaluated in ST_EXEC against the two top
// cells; the stack row shifts when the result commits. A divide launches the bit-serial
// divider from ST_EXEC, runs its 32 quotient steps and commits in ST_DIV once it is done.
// The result register frees the input: the next word is accepted while a result waits,
// and its result commits only once the result register is free.
// Reset (rst, synchronous) empties the stack and drops any pending result; stack cells
// themselves are not cleared, since only entries below the count are ever read.
`default_nettype none

module postfix_stack_evaluator (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [pse_pkg::IN_DATA_W-1:0]       s_axis_tdata,   // number[30:0], zero pad
  input  wire  [pse_pkg::KIND_W-1:0]          s_axis_tuser,   // kind[2:0]
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [pse_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // top_value, status, depth, pad
  output logic                                m_axis_tuser    // is_answer
);

  localparam int W = pse_pkg::DATA_W;

  // Control and token registers
  pse_pkg::state_t                 state;
  pse_pkg::state_t                 state_next;
  pse_pkg::kind_t                  kind;
  logic [pse_pkg::NUM_W-1:0]       number;
  logic [pse_pkg::CNT_W-1:0]       count;
  logic [pse_pkg::CNT_W-1:0]       count_next;

  // Result register
  logic [W-1:0]                    top_value;
  pse_pkg::status_t                status;
  logic [pse_pkg::DEPTH_W-1:0]     depth;
  logic                            is_answer;

  // Evaluation signals
  logic [W-1:0]                    top0;
  logic [W-1:0]                    top1;
  logic [W-1:0]                    res_top;
  pse_pkg::status_t                res_status;
  logic                            res_ans;
  logic                            res_ready;
  pse_pkg::stk_op_t                res_stk_op;
  logic                            div_start;
  logic                            div_done;
  logic [W-1:0]                    div_q;
  logic                            out_free;
  logic                            commit;
  logic                            accept;
  logic                            empty;
  logic                            below_two;
  logic                            full;
  pse_pkg::stk_cmd_t               stk_cmd;

  assign s_axis_tready = (state == pse_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign commit        = res_ready && out_free;

  assign empty     = (count == '0);
  assign below_two = (count < pse_pkg::CNT_W'(2));
  assign full      = (count >= pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH));

  // Evaluate the held token against the top two cells
  always_comb begin
    res_ready  = 1'b0;
    res_top    = '0;
    res_status = pse_pkg::STATUS_OK;
    res_ans    = 1'b0;
    res_stk_op = pse_pkg::STK_HOLD;
    count_next = count;
    div_start  = 1'b0;

    if (state == pse_pkg::ST_DIV) begin
      // Divider finished: replace the two operands with the quotient
      res_ready  = div_done;
      res_top    = div_q;
      res_stk_op = pse_pkg::STK_REPLACE;
      count_next = count - 1'b1;
    end else if (state == pse_pkg::ST_EXEC) begin
      res_ready = 1'b1;
      case (kind) inside
        pse_pkg::KIND_NUMBER: begin
          if (full) begin
            res_status = pse_pkg::STATUS_OVERFLOW;
            count_next = '0;
          end else begin
            res_top    = {1'b0, number};
            res_stk_op = pse_pkg::STK_PUSH;
            count_next = count + 1'b1;
          end
        end
        pse_pkg::KIND_ADD, pse_pkg::KIND_SUB, pse_pkg::KIND_MUL: begin
          if (below_two) begin
            res_status = pse_pkg::STATUS_UNDERFLOW;
            count_next = '0;
          end else begin
            // top1 is the left operand, top0 the right
            case (kind)
              pse_pkg::KIND_ADD: res_top = top1 + top0;
              pse_pkg::KIND_SUB: res_top = top1 - top0;
              default:           res_top = W'(top1 * top0);
            endcase
            res_stk_op = pse_pkg::STK_REPLACE;
            count_next = count - 1'b1;
          end
        end
        pse_pkg::KIND_DIV: begin
          if (below_two) begin
            res_status = pse_pkg::STATUS_UNDERFLOW;
            count_next = '0;
          end else if (top0 == '0) begin
            res_status = pse_pkg::STATUS_DIVZERO;
            count_next = '0;
          end else begin
            // Launch the divider and hold the result until it is done
            res_ready = 1'b0;
            div_start = 1'b1;
          end
        end
        pse_pkg::KIND_FINISH: begin
          if (empty) begin
            res_status = pse_pkg::STATUS_UNDERFLOW;
          end else begin
            res_top = top0;
            res_ans = 1'b1;
          end
          count_next = '0;
        end
        default: begin
          // Unknown kind: report the current top and leave the stack alone
          res_top = empty ? '0 : top0;
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pse_pkg::ST_IDLE: begin
        if (accept) state_next = pse_pkg::ST_EXEC;
      end
      pse_pkg::ST_EXEC: begin
        if (div_start) begin
          state_next = pse_pkg::ST_DIV;
        end else if (commit) begin
          state_next = pse_pkg::ST_IDLE;
        end
      end
      pse_pkg::ST_DIV: begin
        if (commit) state_next = pse_pkg::ST_IDLE;
      end
      default: state_next = pse_pkg::ST_IDLE;
    endcase
  end

  // Stack row command: shift only when the result is committed
  always_comb begin
    stk_cmd.op    = commit ? res_stk_op : pse_pkg::STK_HOLD;
    stk_cmd.value = res_top;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pse_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (commit) count <= count_next;
    end
  end

  // Hold the accepted token
  always_ff @(posedge clk) begin
    if (accept) begin
      kind   <= pse_pkg::kind_t'(s_axis_tuser);
      number <= s_axis_tdata[pse_pkg::NUM_W-1:0];
    end
  end

  // Result register: load on commit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      top_value <= res_top;
      status    <= res_status;
      depth     <= pse_pkg::DEPTH_W'(count_next);
      is_answer <= res_ans;
    end
  end

  assign m_axis_tdata = {{(pse_pkg::OUT_DATA_W - pse_pkg::OUT_FIELD_W){1'b0}},
                         depth, status, top_value};
  assign m_axis_tuser = is_answer;

  pse_stack u_stack (
    .clk  (clk),
    .cmd  (stk_cmd),
    .top0 (top0),
    .top1 (top1)
  );

  pse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (top1),
    .divisor  (top0),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

`default_nettype wire

@@ sim/postfix_stack_evaluator_tb.sv @@
// Self-checking testbench for the postfix stack evaluator: token stream in, one result per token.
`default_nettype none

module postfix_stack_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pse_pkg::*;

  // Kind codes outside the defined set; the block must ignore them.
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  // Cycles with no word moving on either side before the run is declared hung.
  // A divide and random stalls on either side both lengthen such a stretch.
  localparam int STALL_LIMIT = 1000;
  // Drain time after the last expected result (covers a full divide).
  localparam int DRAIN_CYCLES = 40;

  logic                     clk;
  logic                     rst;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [IN_DATA_W-1:0]     s_axis_tdata;   // number[30:0], zero pad
  logic [KIND_W-1:0]        s_axis_tuser;   // kind[2:0]
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OUT_DATA_W-1:0]    m_axis_tdata;   // top_value[31:0], status[33:32], depth[40:34], pad
  logic                     m_axis_tuser;   // is_answer

  postfix_stack_evaluator uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // One evaluation outcome as the block should present it.
  typedef struct packed {
    logic [DATA_W-1:0]   top_value;
    status_t             status;
    logic [DEPTH_W-1:0]  depth;
    logic                is_answer;
  } eval_result_t;

  // Shadow stack kept by the predictor.
  logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
  int unsigned       shadow_count;

  eval_result_t      pending_results [$];
  int                mismatch_count;
  int                results_seen;
  int                tokens_sent;
  int                stall_cycles;
  bit                full_speed;   // suppress idling on both sides

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Signed divide, truncating toward zero; the most negative value over minus
  // one wraps back to itself. Done on magnitudes to stay clear of signed overflow.
  function automatic logic [DATA_W-1:0] quotient_toward_zero(input logic [DATA_W-1:0] lhs,
                                                             input logic [DATA_W-1:0] rhs);
    logic [DATA_W-1:0] mag_l;
    logic [DATA_W-1:0] mag_r;
    logic [DATA_W-1:0] q;
    mag_l = lhs[DATA_W-1] ? (~lhs + 1'b1) : lhs;
    mag_r = rhs[DATA_W-1] ? (~rhs + 1'b1) : rhs;
    q = mag_l / mag_r;
    return (lhs[DATA_W-1] != rhs[DATA_W-1]) ? (~q + 1'b1) : q;
  endfunction

  // Apply one token to the shadow stack and return the result it causes.
  function automatic eval_result_t evaluate_token(input logic [KIND_W-1:0] kind,
                                                  input logic [NUM_W-1:0] number);
    eval_result_t      res;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] acc;
    res.top_value = '0;
    res.status    = STATUS_OK;
    res.depth     = '0;
    res.is_answer = 1'b0;
    acc = '0;
    case (kind)
      KIND_NUMBER: begin
        if (shadow_count >= STACK_DEPTH) begin
          res.status   = STATUS_OVERFLOW;
          shadow_count = 0;
        end else begin
          shadow_stack[shadow_count] = {1'b0, number};
          shadow_count++;
          res.top_value = shadow_stack[shadow_count-1];
        end
      end
      KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
        if (shadow_count < 2) begin
          res.status   = STATUS_UNDERFLOW;
          shadow_count = 0;
        end else begin
          rhs = shadow_stack[shadow_count-1];
          lhs = shadow_stack[shadow_count-2];
          case (kind)
            KIND_ADD: acc = lhs + rhs;
            KIND_SUB: acc = lhs - rhs;
            KIND_MUL: acc = lhs * rhs;
            default: begin
              if (rhs == '0) res.status = STATUS_DIVZERO;
              else acc = quotient_toward_zero(lhs, rhs);
            end
          endcase
          if (res.status != STATUS_OK) begin
            shadow_count = 0;
          end else begin
            shadow_count--;
            shadow_stack[shadow_count-1] = acc;
            res.top_value = acc;
          end
        end
      end
      KIND_FINISH: begin
        // Top entry is the answer; anything under it is thrown away.
        if (shadow_count == 0) begin
          res.status = STATUS_UNDERFLOW;
        end else begin
          res.top_value = shadow_stack[shadow_count-1];
          res.is_answer = 1'b1;
        end
        shadow_count = 0;
      end
      default: begin
        // Spare kinds: no state change, just show the current top.
        if (shadow_count != 0) res.top_value = shadow_stack[shadow_count-1];
      end
    endcase
    res.depth = shadow_count[DEPTH_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Token sender: idle at random, hold the word until accepted, predict on accept
  // ---------------------------------------------------------------------------
  task automatic send_token(input logic [KIND_W-1:0] kind, input logic [NUM_W-1:0] number);
    // Entered at a falling edge; valid may still be high from the last word.
    while (!full_speed && $urandom_range(0, 99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W-NUM_W){1'b0}}, number};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(evaluate_token(kind, number));
    tokens_sent++;
    @(negedge clk);
  endtask

  // Operand mix: mostly small values so divides and zeros show up, plus
  // full-width random values, single-bit values and the extremes.
  function automatic logic [NUM_W-1:0] pick_operand();
    logic [NUM_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = NUM_W'($urandom_range(0, 9));
      1: v = NUM_W'($urandom_range(0, 1000));
      2: v = NUM_W'($urandom);
      3: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = NUM_W'(1);
          2: v = NUM_W'(2);
          3: v = {NUM_W{1'b1}};
          default: v = {1'b1, {(NUM_W-1){1'b0}}};
        endcase
      end
      4: v = NUM_W'(1) << $urandom_range(0, NUM_W-1);
      default: v = NUM_W'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  // Send one well-formed postfix expression with random content and its finish.
  // Sometimes finish early so several entries are still stacked.
  task automatic send_expression(input int operand_count);
    int               pushed;
    int               live;
    bit               leave_extra;
    logic [KIND_W-1:0] op;
    pushed = 0;
    live = 0;
    leave_extra = ($urandom_range(0, 9) == 0);
    while (pushed < operand_count || (live > 1 && !leave_extra)) begin
      if (live < 2 || (pushed < operand_count && $urandom_range(0, 1) == 1)) begin
        send_token(KIND_NUMBER, pick_operand());
        pushed++;
        live++;
      end else begin
        op = KIND_W'($urandom_range(KIND_ADD, KIND_DIV));
        send_token(op, NUM_W'($urandom));
        live--;
      end
    end
    send_token(KIND_FINISH, NUM_W'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the field-by-field check
  // ---------------------------------------------------------------------------
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready <= full_speed || ($urandom_range(0, 99) >= 17);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    eval_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected (data %0h)",
                                  results_seen, m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== want.top_value)
          report_mismatch($sformatf("result %0d top_value: want %0h got %0h",
                                    results_seen, want.top_value, m_axis_tdata[31:0]));
        if (m_axis_tdata[33:32] !== want.status)
          report_mismatch($sformatf("result %0d status: want %0d got %0d",
                                    results_seen, want.status, m_axis_tdata[33:32]));
        if (m_axis_tdata[40:34] !== want.depth)
          report_mismatch($sformatf("result %0d depth: want %0d got %0d",
                                    results_seen, want.depth, m_axis_tdata[40:34]));
        if (m_axis_tuser !== want.is_answer)
          report_mismatch($sformatf("result %0d is_answer: want %0b got %0b",
                                    results_seen, want.is_answer, m_axis_tuser));
      end
      results_seen++;
    end
  end

  // Hang detector: count cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Each operator once, wrap on add, truncating divide of an odd value, finish over two entries.
  task automatic test_basic_ops();
    send_token(KIND_NUMBER, {NUM_W{1'b1}});
    send_token(KIND_NUMBER, '0);
    send_token(KIND_ADD, '0);
    send_token(KIND_NUMBER, NUM_W'(1));
    send_token(KIND_ADD, {NUM_W{1'b1}});   // wraps to the most negative value
    send_token(KIND_NUMBER, NUM_W'(3));
    send_token(KIND_SUB, '0);
    send_token(KIND_NUMBER, NUM_W'(7));
    send_token(KIND_MUL, '0);
    send_token(KIND_NUMBER, NUM_W'(2));
    send_token(KIND_DIV, '0);
    send_token(KIND_NUMBER, NUM_W'(5));
    send_token(KIND_FINISH, {NUM_W{1'b1}});
  endtask

  // Underflow on empty and single-entry stacks, finish on empty, divide by zero.
  task automatic test_error_cases();
    send_token(KIND_ADD, '0);
    send_token(KIND_NUMBER, NUM_W'(5));
    send_token(KIND_SUB, '0);
    send_token(KIND_FINISH, '0);
    send_token(KIND_NUMBER, NUM_W'(5));
    send_token(KIND_NUMBER, '0);
    send_token(KIND_DIV, '0);
  endtask

  // Build the most negative value and minus one, then divide them.
  task automatic test_min_over_minus_one();
    send_token(KIND_NUMBER, {1'b1, {(NUM_W-1){1'b0}}});
    send_token(KIND_NUMBER, NUM_W'(2));
    send_token(KIND_MUL, '0);
    send_token(KIND_NUMBER, '0);
    send_token(KIND_NUMBER, NUM_W'(1));
    send_token(KIND_SUB, '0);
    send_token(KIND_DIV, '0);
    send_token(KIND_FINISH, '0);
  endtask

  // Spare kinds on an empty and a loaded stack.
  task automatic test_spare_kinds();
    send_token(KIND_SPARE_LO, NUM_W'($urandom));
    send_token(KIND_NUMBER, NUM_W'(9));
    send_token(KIND_SPARE_HI, NUM_W'($urandom));
    send_token(KIND_FINISH, '0);
  endtask

  // Fill to the top, overflow, then fill again and reduce all the way down.
  task automatic test_stack_fill();
    send_token(KIND_FINISH, '0);   // start from an empty stack
    repeat (STACK_DEPTH) send_token(KIND_NUMBER, pick_operand());
    send_token(KIND_ADD, '0);
    send_token(KIND_NUMBER, pick_operand());
    send_token(KIND_NUMBER, pick_operand());   // pushes onto a full stack
    repeat (STACK_DEPTH) send_token(KIND_NUMBER, pick_operand());
    repeat (STACK_DEPTH-1)
      send_token(KIND_W'($urandom_range(KIND_ADD, KIND_MUL)), NUM_W'($urandom));
    send_token(KIND_FINISH, '0);
  endtask

  // Mostly well-formed expressions, with bursts of arbitrary tokens in between.
  task automatic test_random_tokens(input int token_budget);
    int stop_at;
    int roll;
    stop_at = tokens_sent + token_budget;
    while (tokens_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        repeat ($urandom_range(1, 4))
          send_token(KIND_W'($urandom_range(0, 7)), NUM_W'($urandom));
      end else if (roll < 92) begin
        send_expression($urandom_range(1, 6));
      end else if (roll < 98) begin
        send_expression($urandom_range(7, 20));
      end else begin
        send_expression($urandom_range(21, STACK_DEPTH));
      end
    end
  endtask

  // Back-to-back words with no idling on either side.
  task automatic test_full_rate(input int token_budget);
    full_speed = 1'b1;
    test_random_tokens(token_budget);
    full_speed = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    mismatch_count = 0;
    results_seen   = 0;
    tokens_sent    = 0;
    stall_cycles   = 0;
    full_speed     = 1'b0;
    shadow_count   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_ops();
    test_error_cases();
    test_min_over_minus_one();
    test_spare_kinds();
    test_stack_fill();
    test_random_tokens(800);
    test_full_rate(300);
    test_random_tokens(700);

    // Drop valid, wait out every expected result, then let the block settle.
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/pse_pkg.sv
hw/rtl/pse_cell.sv
hw/rtl/pse_stack.sv
hw/rtl/pse_div.sv
hw/rtl/postfix_stack_evaluator.sv
sim/postfix_stack_evaluator_tb.sv
